### design/bpf_pkg.sv
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared widths, register indexes and divider stage types.
// ----------------------------------------------------------------------------
package bpf_pkg;

    localparam int SumW = 18;
    localparam int NumW = 35;
    localparam int MagW = 34;
    localparam int QuotW = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 48;

    localparam logic [CfgIdxW-1:0] RegFilterMode = 3'd0;
    localparam logic [CfgIdxW-1:0] RegBoxLow     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegBoxHigh    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegRefPoint   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegAxisLimits = 3'd4;
    localparam logic [CfgIdxW-1:0] RegLineLimit  = 3'd5;

    typedef struct packed {
        logic [MagW-1:0]  rem;
        logic [QuotW-1:0] quot;
        logic             neg;
    } div_lane_t;

endpackage

### design/bpf_divider.sv
// ----------------------------------------------------------------------------
// bpf_divider
// Pipelined restoring divider, three axes, 16 quotient bits in 8 stages.
// Quotient of a magnitude below 2^16 times divisor; sign applied at the end.
// ----------------------------------------------------------------------------
module bpf_divider (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [bpf_pkg::SumW-1:0]           den_in,
    input  logic [2:0][bpf_pkg::MagW-1:0]      mag_in,
    input  logic [2:0]                         neg_in,
    output logic [2:0][bpf_pkg::QuotW-1:0]     quot_out
);
    import bpf_pkg::*;

    localparam int Stages = 8;
    localparam int BitsPer = QuotW / Stages;

    div_lane_t [2:0] lane_reg [Stages];
    logic [SumW-1:0] den_reg [Stages];

    function automatic div_lane_t step(div_lane_t l, logic [SumW-1:0] d, int bitpos);
        logic [MagW-1:0] trial;
        div_lane_t r;
        r = l;
        trial = {{(MagW-SumW){1'b0}}, d} << bitpos;
        if (r.rem >= trial) begin
            r.rem = r.rem - trial;
            r.quot[bitpos] = 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < Stages; s++) begin
                for (int a = 0; a < 3; a++) begin
                    div_lane_t l;
                    if (s == 0) begin
                        l.rem = mag_in[a];
                        l.quot = '0;
                        l.neg = neg_in[a];
                    end else begin
                        l = lane_reg[s-1][a];
                    end
                    for (int b = 0; b < BitsPer; b++) begin
                        l = step(l, (s == 0) ? den_in : den_reg[s-1],
                                 QuotW - 1 - s*BitsPer - b);
                    end
                    lane_reg[s][a] <= l;
                end
                den_reg[s] <= (s == 0) ? den_in : den_reg[s-1];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            quot_out[a] = lane_reg[Stages-1][a].neg ? -lane_reg[Stages-1][a].quot
                                                    : lane_reg[Stages-1][a].quot;
        end
    end
endmodule

### design/barycentric_point_filter.sv
// ----------------------------------------------------------------------------
// barycentric_point_filter
// Weighted vertex mean with box or near-point cull.
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_        in   s_valid / s_ready    va_*, vb_*, vc_*, weight0..2
// m_        out  m_valid / m_ready    keep, pos_x/y/z, degenerate
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
// One beat per cycle unless stalled; stages: multiply, sum, 8 divider stages,
// distance, squares, compare. The whole pipe advances when the output
// register is empty or taken, so a stall holds every stage. Reset clears
// the valid bits and the configuration registers.
module barycentric_point_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_va_x, s_va_y, s_va_z,
    input  logic signed [15:0]             s_vb_x, s_vb_y, s_vb_z,
    input  logic signed [15:0]             s_vc_x, s_vc_y, s_vc_z,
    input  logic [15:0]                    s_weight0, s_weight1, s_weight2,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_keep,
    output logic signed [15:0]             m_pos_x, m_pos_y, m_pos_z,
    output logic                           m_degenerate,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpf_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [bpf_pkg::CfgDataW-1:0]   cfg_data
);
    import bpf_pkg::*;

    localparam int Depth = 13;
    localparam int DivStages = 8;

    logic mode_reg;
    logic [47:0] box_low_reg, box_high_reg, ref_reg, lim_reg;
    logic [15:0] line_reg;

    assign cfg_ready = aresetn;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0; box_low_reg <= '0; box_high_reg <= '0;
            ref_reg <= '0; lim_reg <= '0; line_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                RegFilterMode: mode_reg <= cfg_data[0];
                RegBoxLow:     box_low_reg <= cfg_data;
                RegBoxHigh:    box_high_reg <= cfg_data;
                RegRefPoint:   ref_reg <= cfg_data;
                RegAxisLimits: lim_reg <= cfg_data;
                RegLineLimit:  line_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [Depth-1:0] vld_reg;
    logic en;
    assign en = !vld_reg[Depth-1] || m_ready;
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[Depth-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[Depth-2:0], s_valid};
    end

    // stage 1: products and weight sum
    logic signed [32:0] prod_reg [3][3];
    logic [SumW-1:0] sum1_reg;
    logic signed [15:0] va [3], vb [3], vc [3];
    assign va = '{s_va_x, s_va_y, s_va_z};
    assign vb = '{s_vb_x, s_vb_y, s_vb_z};
    assign vc = '{s_vc_x, s_vc_y, s_vc_z};

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                prod_reg[a][0] <= va[a] * $signed({1'b0, s_weight1});
                prod_reg[a][1] <= vb[a] * $signed({1'b0, s_weight2});
                prod_reg[a][2] <= vc[a] * $signed({1'b0, s_weight0});
            end
            sum1_reg <= SumW'(s_weight0) + SumW'(s_weight1) + SumW'(s_weight2);
        end
    end

    // stage 2: numerator magnitude and sign
    logic [2:0][MagW-1:0] mag_reg;
    logic [2:0] neg_reg;
    logic [SumW-1:0] sum2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                logic signed [NumW-1:0] n;
                n = NumW'(prod_reg[a][0]) + NumW'(prod_reg[a][1]) + NumW'(prod_reg[a][2]);
                neg_reg[a] <= n[NumW-1];
                mag_reg[a] <= n[NumW-1] ? MagW'(-n) : MagW'(n);
            end
            sum2_reg <= sum1_reg;
        end
    end

    logic [2:0][QuotW-1:0] quot;
    bpf_divider u_div (
        .aclk(aclk), .en(en), .den_in(sum2_reg),
        .mag_in(mag_reg), .neg_in(neg_reg), .quot_out(quot)
    );

    logic deg_reg [DivStages];
    always_ff @(posedge aclk) begin
        if (en) begin
            deg_reg[0] <= (sum2_reg == '0);
            for (int s = 1; s < DivStages; s++) deg_reg[s] <= deg_reg[s-1];
        end
    end

    // stage 11: position, distances, box and axis-limit tests
    logic signed [15:0] p3_reg [3];
    logic [15:0] d3_reg [3];
    logic deg3_reg, box3_reg, ax3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            logic inbox, axdrop;
            inbox = 1'b1;
            axdrop = 1'b0;
            for (int a = 0; a < 3; a++) begin
                logic signed [15:0] p;
                logic signed [16:0] df;
                logic [15:0] d;
                p = deg_reg[DivStages-1] ? '0 : $signed(quot[a]);
                df = 17'($signed(ref_reg[16*a +: 16])) - 17'(p);
                d = df[16] ? 16'(-df) : df[15:0];
                if (p < $signed(box_low_reg[16*a +: 16]) ||
                    p > $signed(box_high_reg[16*a +: 16])) inbox = 1'b0;
                if (d < lim_reg[16*a +: 16]) axdrop = 1'b1;
                p3_reg[a] <= p;
                d3_reg[a] <= d;
            end
            deg3_reg <= deg_reg[DivStages-1];
            box3_reg <= inbox;
            ax3_reg <= axdrop;
        end
    end

    // stage 12: squares
    logic [31:0] sq_reg [3];
    logic [31:0] l2_reg;
    logic signed [15:0] p4_reg [3];
    logic deg4_reg, box4_reg, ax4_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                sq_reg[a] <= d3_reg[a] * d3_reg[a];
                p4_reg[a] <= p3_reg[a];
            end
            l2_reg <= line_reg * line_reg;
            deg4_reg <= deg3_reg;
            box4_reg <= box3_reg;
            ax4_reg <= ax3_reg;
        end
    end

    // stage 13: output
    logic keep_reg, degen_reg;
    logic signed [15:0] pos_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            logic [33:0] d2;
            d2 = 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]);
            keep_reg <= mode_reg ? !(ax4_reg || d2 < 34'(l2_reg)) : box4_reg;
            degen_reg <= deg4_reg;
            for (int a = 0; a < 3; a++) pos_reg[a] <= p4_reg[a];
        end
    end

    assign m_keep = keep_reg;
    assign m_degenerate = degen_reg;
    assign m_pos_x = pos_reg[0];
    assign m_pos_y = pos_reg[1];
    assign m_pos_z = pos_reg[2];
endmodule
